// ===== rtl/core/olbg_pkg.sv =====
// ----------------------------------------------------------------------------
// olbg_pkg
// Shared widths, command types and helpers for the offset list block GCD unit.
// ----------------------------------------------------------------------------
package olbg_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int COUNT_BITS  = 32;
    localparam int SHIFT_BITS  = $clog2(OFFSET_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_ABITS = $clog2(QUEUE_DEPTH);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [SHIFT_BITS-1:0]  shift_t;
    typedef logic [QUEUE_ABITS-1:0] qptr_t;
    typedef logic [QUEUE_ABITS:0]   qcount_t;

    typedef enum logic [1:0] {
        CMD_FOLD,
        CMD_FINAL,
        CMD_DIRECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        offset_t   value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_OUT
    } back_state_t;

    localparam count_t COUNT_MAX = '1;

    function automatic count_t sat_inc(count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    function automatic offset_t widen_count(count_t c);
        return offset_t'(c);
    endfunction

endpackage

// ===== rtl/core/olbg_in_if.sv =====
// ----------------------------------------------------------------------------
// olbg_in_if
// Offset channel: one offset per beat, with a flag on the final offset.
// ----------------------------------------------------------------------------
interface olbg_in_if;
    logic                            valid;
    logic                            ready;
    logic [olbg_pkg::OFFSET_BITS-1:0] offset;
    logic                            last;

    modport source (output valid, output offset, output last, input ready);
    modport sink   (input valid, input offset, input last, output ready);
endinterface

// ===== rtl/core/olbg_out_if.sv =====
// ----------------------------------------------------------------------------
// olbg_out_if
// Result channel: one block size per beat.
// ----------------------------------------------------------------------------
interface olbg_out_if;
    logic                            valid;
    logic                            ready;
    logic [olbg_pkg::OFFSET_BITS-1:0] block_size;

    modport source (output valid, output block_size, input ready);
    modport sink   (input valid, input block_size, output ready);
endinterface

// ===== rtl/core/olbg_front.sv =====
// ----------------------------------------------------------------------------
// olbg_front
// Tracks runs and gaps of the offset list and issues GCD commands.
// ----------------------------------------------------------------------------
module olbg_front (
    input  logic                    clk,
    input  logic                    rst_n,
    olbg_in_if.sink                 items,
    input  olbg_pkg::queue_status_t q_status,
    output logic                    push,
    output olbg_pkg::cmd_t          push_cmd
);
    import olbg_pkg::*;

    offset_t   prev_offset_reg, prev_offset_next;
    offset_t   first_offset_reg, first_offset_next;
    logic      first_pending_reg, first_pending_next;
    count_t    run_length_reg, run_length_next;
    count_t    items_seen_reg, items_seen_next;
    logic      any_break_reg, any_break_next;
    logic      prev_was_gap_reg, prev_was_gap_next;
    logic      forced_one_reg, forced_one_next;

    logic      len_pend_reg;
    offset_t   len_val_reg;
    logic      gap_pend_reg;
    offset_t   gap_val_reg;
    logic      fin_pend_reg;
    cmd_kind_t fin_kind_reg;
    offset_t   fin_val_reg;

    logic      accept;
    logic      rises;
    offset_t   delta;
    offset_t   gap;
    logic      len_fold;
    logic      len_final;
    logic      gap_fold;
    cmd_kind_t fin_kind;
    offset_t   fin_val;
    offset_t   len_val;

    assign items.ready = !(len_pend_reg || gap_pend_reg || fin_pend_reg);
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        rises              = items.offset > prev_offset_reg;
        delta              = items.offset - prev_offset_reg;
        gap                = delta - offset_t'(1);
        prev_offset_next   = items.offset;
        first_offset_next  = first_offset_reg;
        first_pending_next = items.last;
        run_length_next    = run_length_reg;
        items_seen_next    = sat_inc(items_seen_reg);
        any_break_next     = any_break_reg;
        prev_was_gap_next  = prev_was_gap_reg;
        forced_one_next    = forced_one_reg;
        len_fold           = 1'b0;
        gap_fold           = 1'b0;

        if (first_pending_reg)
        begin
            first_offset_next = items.offset;
            run_length_next   = count_t'(1);
            items_seen_next   = count_t'(1);
            any_break_next    = 1'b0;
            prev_was_gap_next = 1'b0;
            forced_one_next   = 1'b0;
        end
        else if (rises && (delta == offset_t'(1)))
        begin
            run_length_next   = sat_inc(run_length_reg);
            prev_was_gap_next = 1'b0;
        end
        else
        begin
            if (prev_was_gap_reg || (run_length_reg <= count_t'(1)))
            begin
                forced_one_next = 1'b1;
            end
            len_fold = run_length_reg > count_t'(1);
            if (rises)
            begin
                if (gap <= offset_t'(1))
                begin
                    forced_one_next = 1'b1;
                end
                else
                begin
                    gap_fold = 1'b1;
                end
                prev_was_gap_next = 1'b1;
            end
            else
            begin
                prev_was_gap_next = 1'b0;
            end
            any_break_next  = 1'b1;
            run_length_next = count_t'(1);
        end

        len_final = 1'b0;
        if (!any_break_next)
        begin
            fin_kind = CMD_DIRECT;
            fin_val  = widen_count(items_seen_next);
        end
        else if (forced_one_next || (run_length_next <= count_t'(1)))
        begin
            fin_kind = CMD_DIRECT;
            fin_val  = offset_t'(1);
        end
        else
        begin
            fin_kind  = CMD_FINAL;
            fin_val   = first_offset_next;
            len_final = items.last;
        end

        len_val = len_fold ? widen_count(run_length_reg) : widen_count(run_length_next);
    end

    always_comb
    begin
        push     = !q_status.full && (len_pend_reg || gap_pend_reg || fin_pend_reg);
        push_cmd = '{kind: fin_kind_reg, value: fin_val_reg};
        if (len_pend_reg)
        begin
            push_cmd = '{kind: CMD_FOLD, value: len_val_reg};
        end
        else if (gap_pend_reg)
        begin
            push_cmd = '{kind: CMD_FOLD, value: gap_val_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_offset_reg   <= '0;
            first_offset_reg  <= '0;
            first_pending_reg <= 1'b1;
            run_length_reg    <= '0;
            items_seen_reg    <= '0;
            any_break_reg     <= 1'b0;
            prev_was_gap_reg  <= 1'b0;
            forced_one_reg    <= 1'b0;
            len_pend_reg      <= 1'b0;
            gap_pend_reg      <= 1'b0;
            fin_pend_reg      <= 1'b0;
        end
        else if (accept)
        begin
            prev_offset_reg   <= prev_offset_next;
            first_offset_reg  <= first_offset_next;
            first_pending_reg <= first_pending_next;
            run_length_reg    <= run_length_next;
            items_seen_reg    <= items_seen_next;
            any_break_reg     <= any_break_next;
            prev_was_gap_reg  <= prev_was_gap_next;
            forced_one_reg    <= forced_one_next;
            len_pend_reg      <= len_fold || len_final;
            gap_pend_reg      <= gap_fold;
            fin_pend_reg      <= items.last;
        end
        else if (push)
        begin
            if (len_pend_reg)
            begin
                len_pend_reg <= 1'b0;
            end
            else if (gap_pend_reg)
            begin
                gap_pend_reg <= 1'b0;
            end
            else
            begin
                fin_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_val_reg  <= len_val;
            gap_val_reg  <= gap;
            fin_kind_reg <= fin_kind;
            fin_val_reg  <= fin_val;
        end
    end

endmodule

// ===== rtl/core/olbg_queue.sv =====
// ----------------------------------------------------------------------------
// olbg_queue
// Short command queue between the classifying front and the GCD back end.
// ----------------------------------------------------------------------------
module olbg_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  olbg_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output olbg_pkg::cmd_t          head,
    output olbg_pkg::queue_status_t status
);
    import olbg_pkg::*;

    cmd_t    entries_reg [QUEUE_DEPTH];
    qptr_t   wr_ptr_reg;
    qptr_t   rd_ptr_reg;
    qcount_t count_reg;

    assign head            = entries_reg[rd_ptr_reg];
    assign status.full     = count_reg == qcount_t'(QUEUE_DEPTH);
    assign status.nonempty = count_reg != qcount_t'(0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + qptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + qptr_t'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + qcount_t'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - qcount_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/olbg_back.sv =====
// ----------------------------------------------------------------------------
// olbg_back
// Binary GCD engine that folds commands into a running GCD and emits results.
// ----------------------------------------------------------------------------
module olbg_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  olbg_pkg::cmd_t          head,
    input  olbg_pkg::queue_status_t q_status,
    output logic                    pop,
    olbg_out_if.source              results
);
    import olbg_pkg::*;

    back_state_t state_reg, state_next;
    offset_t     acc_reg;
    offset_t     a_reg;
    offset_t     b_reg;
    shift_t      k_reg;
    cmd_kind_t   kind_reg;
    offset_t     res_reg;
    logic        out_valid_reg;
    offset_t     out_val_reg;

    logic        gcd_done;
    offset_t     gcd_res;
    logic        out_load;

    assign gcd_done          = (a_reg == '0) || (b_reg == '0);
    assign gcd_res           = (a_reg | b_reg) << k_reg;
    assign results.valid     = out_valid_reg;
    assign results.block_size = out_val_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_status.nonempty)
                begin
                    state_next = (head.kind == CMD_DIRECT) ? BK_OUT : BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (gcd_done)
                begin
                    state_next = (kind_reg == CMD_FINAL) ? BK_OUT : BK_IDLE;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == BK_IDLE) && q_status.nonempty;
        out_load = (state_reg == BK_OUT) && (!out_valid_reg || results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && (head.kind == CMD_DIRECT))
            begin
                acc_reg <= '0;
            end
            else if ((state_reg == BK_RUN) && gcd_done)
            begin
                acc_reg <= (kind_reg == CMD_FINAL) ? '0 : gcd_res;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.kind;
            res_reg  <= head.value;
            a_reg    <= acc_reg;
            b_reg    <= head.value;
            k_reg    <= '0;
        end
        else if (state_reg == BK_RUN)
        begin
            if (gcd_done)
            begin
                res_reg <= gcd_res;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + shift_t'(1);
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
        if (out_load)
        begin
            out_val_reg <= res_reg;
        end
    end

endmodule

// ===== rtl/core/offset_list_block_gcd_unit.sv =====
// ----------------------------------------------------------------------------
// offset_list_block_gcd_unit
// Operation: a final offset yields its block size after the front issues its
// commands (one per cycle while the queue has room, up to three) and the back
// end folds each non-direct command with a binary GCD and registers the result.
// Throughput: an offset that issues no command is taken every cycle; one that
// issues commands holds the input until all of them are pushed, waiting while the queue is full.
// Reset is asynchronous and clears all list tracking state; no clearing pass.
// ----------------------------------------------------------------------------
module offset_list_block_gcd_unit (
    input  logic       clk,
    input  logic       rst_n,
    olbg_in_if.sink    items,
    olbg_out_if.source results
);
    import olbg_pkg::*;

    logic          q_push;
    cmd_t          q_push_cmd;
    logic          q_pop;
    cmd_t          q_head;
    queue_status_t q_status;

    olbg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .q_status (q_status),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    olbg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    olbg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .results  (results)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full))
        else $error("Command written into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.nonempty)
        else $error("Command taken from an empty queue.");

    a_nonzero_result: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.block_size != '0))
        else $error("Block size of zero presented.");
`endif

endmodule
